// File: sv/psl_pkg.sv
// Shared types, constants and palette tables of the status LED controller.
package psl_pkg;

    localparam int STATUS_COUNT = 11;
    localparam int IDX_W = 4;
    localparam int DUR_W = 16;
    localparam int TICK_W = 9;
    localparam int PHASE_W = 11;
    localparam int BLINK_COUNT = 4;

    localparam logic [TICK_W-1:0] TICK_PERIOD_RESET = 9'd100;
    localparam logic [IDX_W-1:0] RESET_STATUS = 4'd9;
    localparam logic [IDX_W-1:0] NONE_SHOWN = 4'd15;

    localparam logic [2:0] OP_SET = 3'd0;
    localparam logic [2:0] OP_SET_TIMED = 3'd1;
    localparam logic [2:0] OP_CLEAR = 3'd2;
    localparam logic [2:0] OP_CLEAR_ALL = 3'd3;
    localparam logic [2:0] OP_TICK = 3'd4;

    typedef struct packed {
        logic [2:0]       op;
        logic [IDX_W-1:0] status_index;
        logic [DUR_W-1:0] duration_ms;
    } psl_cmd_t;

    typedef struct packed {
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [IDX_W-1:0] shown_status;
    } psl_led_t;

    typedef struct packed {
        logic              set;
        logic              set_timed;
        logic              clear;
        logic              clear_all;
        logic              tick;
        logic [IDX_W-1:0]  status_index;
        logic [DUR_W-1:0]  duration_ms;
        logic [TICK_W-1:0] tick_period_ms;
    } psl_cell_cmd_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] sel;
    } psl_chain_t;

    typedef struct packed {
        logic       en;
        logic [1:0] sel;
    } psl_blink_t;

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_TICK,
        PEND_CLEAR
    } psl_pend_t;

    function automatic logic [PHASE_W-1:0] blink_period(input logic [1:0] k);
        logic [PHASE_W-1:0] p;
        unique case (k)
            2'd0: p = 11'd300;
            2'd1: p = 11'd500;
            2'd2: p = 11'd1000;
            default: p = 11'd1500;
        endcase
        return p;
    endfunction

    function automatic psl_led_t palette(input logic [IDX_W-1:0] idx);
        psl_led_t c;
        c.shown_status = idx;
        unique case (idx)
            4'd0: {c.red, c.green, c.blue} = {8'd255, 8'd0, 8'd0};
            4'd1: {c.red, c.green, c.blue} = {8'd255, 8'd0, 8'd0};
            4'd2: {c.red, c.green, c.blue} = {8'd0, 8'd255, 8'd0};
            4'd3: {c.red, c.green, c.blue} = {8'd255, 8'd200, 8'd0};
            4'd4: {c.red, c.green, c.blue} = {8'd255, 8'd100, 8'd0};
            4'd5: {c.red, c.green, c.blue} = {8'd0, 8'd150, 8'd255};
            4'd6: {c.red, c.green, c.blue} = {8'd0, 8'd255, 8'd0};
            4'd7: {c.red, c.green, c.blue} = {8'd0, 8'd80, 8'd255};
            4'd8: {c.red, c.green, c.blue} = {8'd120, 8'd0, 8'd200};
            4'd9: {c.red, c.green, c.blue} = {8'd60, 8'd60, 8'd60};
            default: {c.red, c.green, c.blue} = {8'd0, 8'd0, 8'd0};
        endcase
        return c;
    endfunction

    function automatic psl_blink_t blink_of(input logic [IDX_W-1:0] idx);
        psl_blink_t b;
        unique case (idx)
            4'd0: b = '{en: 1'b1, sel: 2'd0};
            4'd3: b = '{en: 1'b1, sel: 2'd1};
            4'd4: b = '{en: 1'b1, sel: 2'd2};
            4'd5: b = '{en: 1'b1, sel: 2'd1};
            4'd7: b = '{en: 1'b1, sel: 2'd3};
            default: b = '{en: 1'b0, sel: 2'd0};
        endcase
        return b;
    endfunction

endpackage

// File: sv/psl_cell.sv
// One status cell: active and timed bits, remaining time, priority chain link.
module psl_cell #(
    parameter logic [psl_pkg::IDX_W-1:0] CELL_INDEX = '0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  psl_pkg::psl_cell_cmd_t cmd,
    input  psl_pkg::psl_chain_t   chain_in,
    output psl_pkg::psl_chain_t   chain_out
);

    logic                       active_reg;
    logic                       active_next;
    logic                       timed_reg;
    logic                       timed_next;
    logic [psl_pkg::DUR_W-1:0]  remaining_reg;
    logic [psl_pkg::DUR_W-1:0]  remaining_next;
    logic                       hit;
    logic [psl_pkg::DUR_W-1:0]  tick_ext;
    logic                       expire;

    assign hit      = cmd.status_index == CELL_INDEX;
    assign tick_ext = psl_pkg::DUR_W'(cmd.tick_period_ms);
    assign expire   = remaining_reg <= tick_ext;

    always_comb
    begin
        active_next    = active_reg;
        timed_next     = timed_reg;
        remaining_next = remaining_reg;
        priority if (cmd.clear_all)
        begin
            active_next = 1'b0;
            timed_next  = 1'b0;
        end
        else if (cmd.tick)
        begin
            if (timed_reg)
            begin
                if (expire)
                begin
                    remaining_next = '0;
                    timed_next     = 1'b0;
                    active_next    = 1'b0;
                end
                else
                begin
                    remaining_next = remaining_reg - tick_ext;
                end
            end
        end
        else if (hit && cmd.set)
        begin
            active_next = 1'b1;
            timed_next  = 1'b0;
        end
        else if (hit && cmd.set_timed)
        begin
            active_next    = 1'b1;
            timed_next     = 1'b1;
            remaining_next = cmd.duration_ms;
        end
        else if (hit && cmd.clear)
        begin
            active_next = 1'b0;
            timed_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= CELL_INDEX == psl_pkg::RESET_STATUS;
            timed_reg  <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            timed_reg  <= timed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        remaining_reg <= remaining_next;
    end

    // pass the first active index down the row
    always_comb
    begin
        chain_out.found = chain_in.found | active_reg;
        chain_out.sel   = chain_in.found ? chain_in.sel : CELL_INDEX;
    end

endmodule

// File: sv/psl_blink.sv
// Blink phase counters, one per blink period, and their on/off halves.
module psl_blink (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         tick,
    input  logic [psl_pkg::TICK_W-1:0]   tick_period_ms,
    output logic [psl_pkg::BLINK_COUNT-1:0] blink_on
);

    logic [psl_pkg::PHASE_W-1:0] phase_reg  [psl_pkg::BLINK_COUNT];
    logic [psl_pkg::PHASE_W-1:0] phase_next [psl_pkg::BLINK_COUNT];

    for (genvar k = 0; k < psl_pkg::BLINK_COUNT; k++)
    begin : g_lane
        logic [psl_pkg::PHASE_W:0] period;
        logic [psl_pkg::PHASE_W:0] sum;
        logic [psl_pkg::PHASE_W:0] once;
        logic [psl_pkg::PHASE_W:0] twice;

        assign period = {1'b0, psl_pkg::blink_period(2'(k))};
        assign sum    = {1'b0, phase_reg[k]} + (psl_pkg::PHASE_W + 1)'(tick_period_ms);
        assign once   = (sum >= period) ? sum - period : sum;
        assign twice  = (once >= period) ? once - period : once;

        always_comb
        begin
            phase_next[k] = tick ? twice[psl_pkg::PHASE_W-1:0] : phase_reg[k];
        end

        assign blink_on[k] = {phase_reg[k], 1'b0} < period;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                phase_reg[k] <= '0;
            else
                phase_reg[k] <= phase_next[k];
        end
    end

endmodule

// File: sv/priority_status_led_controller.sv
// Top level of the prioritized status LED controller.
// Set, timed set and clear commands do not stall the input. A tick or a
// clear-all beat updates the cells as it is accepted; then, in the pending
// state, the priority chain through the cells resolves the shown status for
// a tick (a clear-all shows the off status), and the result loads the
// output register; the input is stalled in the pending state, and longer
// while the output register holds an untaken beat. A tick that keeps a
// steady status unchanged gives no output beat. Timed statuses count down in tick_period_ms steps per tick.
module priority_status_led_controller #(
    parameter int STATUS_COUNT = psl_pkg::STATUS_COUNT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_stall,
    input  psl_pkg::psl_cmd_t          cmd,
    output logic                       led_valid,
    input  logic                       led_stall,
    output psl_pkg::psl_led_t          led,
    input  logic                       cfg_we,
    input  logic [psl_pkg::TICK_W-1:0] cfg_data
);

    localparam logic [psl_pkg::IDX_W-1:0] OFF_STATUS = psl_pkg::IDX_W'(STATUS_COUNT - 1);

    logic [psl_pkg::TICK_W-1:0]   tick_period_reg;
    psl_pkg::psl_pend_t           pend_reg;
    psl_pkg::psl_pend_t           pend_next;
    logic [psl_pkg::IDX_W-1:0]    last_shown_reg;
    logic [psl_pkg::IDX_W-1:0]    last_shown_next;
    logic                         led_valid_reg;
    logic                         led_valid_next;
    psl_pkg::psl_led_t            led_reg;
    psl_pkg::psl_led_t            led_next;

    logic                         accept;
    logic                         slot_free;
    logic                         emit;
    psl_pkg::psl_led_t            emit_data;
    psl_pkg::psl_cell_cmd_t       cell_cmd;
    psl_pkg::psl_chain_t          chain [STATUS_COUNT+1];
    logic [psl_pkg::IDX_W-1:0]    shown;
    psl_pkg::psl_blink_t          blink;
    logic [psl_pkg::BLINK_COUNT-1:0] blink_on;

    assign cmd_stall = pend_reg != psl_pkg::PEND_NONE;
    assign accept    = cmd_valid && !cmd_stall;
    assign slot_free = !led_valid_reg || !led_stall;

    always_comb
    begin
        cell_cmd.set            = accept && cmd.op == psl_pkg::OP_SET;
        cell_cmd.set_timed      = accept && cmd.op == psl_pkg::OP_SET_TIMED;
        cell_cmd.clear          = accept && cmd.op == psl_pkg::OP_CLEAR;
        cell_cmd.clear_all      = accept && cmd.op == psl_pkg::OP_CLEAR_ALL;
        cell_cmd.tick           = accept && cmd.op == psl_pkg::OP_TICK;
        cell_cmd.status_index   = cmd.status_index;
        cell_cmd.duration_ms    = cmd.duration_ms;
        cell_cmd.tick_period_ms = tick_period_reg;
    end

    assign chain[0] = '{found: 1'b0, sel: OFF_STATUS};

    for (genvar i = 0; i < STATUS_COUNT; i++)
    begin : g_cell
        psl_cell #(
            .CELL_INDEX(psl_pkg::IDX_W'(i))
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cell_cmd),
            .chain_in (chain[i]),
            .chain_out(chain[i+1])
        );
    end

    assign shown = chain[STATUS_COUNT].sel;
    assign blink = psl_pkg::blink_of(shown);

    psl_blink u_blink (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick          (cell_cmd.tick),
        .tick_period_ms(tick_period_reg),
        .blink_on      (blink_on)
    );

    // next state
    always_comb
    begin
        pend_next = pend_reg;
        unique case (pend_reg)
            psl_pkg::PEND_NONE:
            begin
                if (cell_cmd.tick)
                    pend_next = psl_pkg::PEND_TICK;
                else if (cell_cmd.clear_all)
                    pend_next = psl_pkg::PEND_CLEAR;
            end
            psl_pkg::PEND_TICK,
            psl_pkg::PEND_CLEAR:
            begin
                if (slot_free)
                    pend_next = psl_pkg::PEND_NONE;
            end
            default: pend_next = psl_pkg::PEND_NONE;
        endcase
    end

    // outputs
    always_comb
    begin
        emit      = 1'b0;
        emit_data = psl_pkg::palette(shown);
        unique case (pend_reg)
            psl_pkg::PEND_TICK:
            begin
                emit = slot_free && (blink.en || shown != last_shown_reg);
                if (blink.en && !blink_on[blink.sel])
                    emit_data = '{red: 8'd0, green: 8'd0, blue: 8'd0, shown_status: shown};
            end
            psl_pkg::PEND_CLEAR:
            begin
                emit      = slot_free;
                emit_data = '{red: 8'd0, green: 8'd0, blue: 8'd0, shown_status: OFF_STATUS};
            end
            default: emit = 1'b0;
        endcase
    end

    always_comb
    begin
        last_shown_next = emit ? emit_data.shown_status : last_shown_reg;
        led_next        = emit ? emit_data : led_reg;
        if (emit)
            led_valid_next = 1'b1;
        else if (!led_stall)
            led_valid_next = 1'b0;
        else
            led_valid_next = led_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_period_reg <= psl_pkg::TICK_PERIOD_RESET;
            pend_reg        <= psl_pkg::PEND_NONE;
            last_shown_reg  <= psl_pkg::NONE_SHOWN;
            led_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                tick_period_reg <= cfg_data;
            pend_reg       <= pend_next;
            last_shown_reg <= last_shown_next;
            led_valid_reg  <= led_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        led_reg <= led_next;
    end

    assign led_valid = led_valid_reg;
    assign led       = led_reg;

endmodule
